### design/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared constants and types for the Goppa syndrome accumulator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int MAX_POINTS   = 8192;
  localparam int SYNDROME_LEN = 256;
  localparam int GF_WIDTH     = 13;
  localparam int LANES        = 8;

  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int LANE_W  = $clog2(LANES);
  localparam int ROW_W   = PT_W - LANE_W;
  localparam int COL_W   = $clog2(SYNDROME_LEN);
  localparam int BANK_AW = ROW_W + COL_W;
  localparam int PIU_W   = 14;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ACCUM = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_READ
  } state_e;

  typedef logic [LANES-1:0][GF_WIDTH-1:0] lane_data_t;

  typedef struct packed {
    logic [LANES-1:0] mask;
    logic             acc_valid;
  } merge_ctrl_t;

endpackage

### design/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/gsa_merge.sv
// ----------------------------------------------------------------------------
// gsa_merge
// Merging stage: xors the selected lane rows into one accumulator word.
// ----------------------------------------------------------------------------
module gsa_merge
  import gsa_pkg::*;
(
  input  merge_ctrl_t         ctrl_i,
  input  lane_data_t          lane_i,
  input  logic [GF_WIDTH-1:0] acc_i,
  output logic [GF_WIDTH-1:0] sum_o
);

  always_comb begin
    sum_o = ctrl_i.acc_valid ? acc_i : '0;
    for (int b = 0; b < LANES; b++) begin
      if (ctrl_i.mask[b]) begin
        sum_o = sum_o ^ lane_i[b];
      end
    end
  end

endmodule

### design/goppa_syndrome_accumulator_unit.sv
// ----------------------------------------------------------------------------
// goppa_syndrome_accumulator_unit
// Syndrome accumulation over a lane-banked coefficient table.
// ----------------------------------------------------------------------------
// Input beats carry a command: table write, syndrome clear, byte accumulate
// or syndrome read. Only a read produces an output beat (syndrome_word_o,
// word_index_o), valid once the accumulator read register and then the
// output register are loaded, and held there until taken; no new beat is
// taken before that. Table writes and clears complete in idle. An accumulate
// sweeps all syndrome words: eight lane banks, one per bit of the byte, each
// read one word per cycle, then a drain state; no new beat is taken until
// the sweep is done. points_in_use is written through cfg_valid_i /
// cfg_data_i, always ready. Reset clears the syndrome valid bits at once, so
// no clearing pass is needed; the table is undefined until written. When the
// receiver stalls, a read waits on a full output register, taking no new beat.
// ----------------------------------------------------------------------------
module goppa_syndrome_accumulator_unit
  import gsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PIU_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [12:0]         point_index_i,
  input  logic [7:0]          power_index_i,
  input  logic [12:0]         table_value_i,
  input  logic [9:0]          byte_index_i,
  input  logic [7:0]          cipher_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [12:0]         syndrome_word_o,
  output logic [7:0]          word_index_o
);

  state_e state_q, state_d;
  logic [PIU_W-1:0]        piu_q;
  logic [ROW_W-1:0]        row_q;
  logic [LANES-1:0]        mask_q;
  logic [COL_W-1:0]        col_q;
  logic                    wb_q;
  logic [COL_W-1:0]        wb_col_q;
  logic [SYNDROME_LEN-1:0] vld_q;
  logic [COL_W-1:0]        rd_idx_q;
  logic                    out_valid_q;
  logic [GF_WIDTH-1:0]     syn_q;
  logic [7:0]              idx_q;

  logic       in_acc;
  cmd_e       cmd;
  logic [LANES-1:0] mask_new;
  logic       acc_re, out_load, last_col;
  logic [COL_W-1:0] acc_raddr;
  lane_data_t lane_data;
  logic [GF_WIDTH-1:0] acc_rdata, sum;
  merge_ctrl_t mctrl;

  assign cmd         = cmd_e'(command_i);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign last_col    = (col_q == COL_W'(SYNDROME_LEN - 1));
  assign out_load    = (state_q == ST_READ) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      mask_new[b] = cipher_byte_i[b] &&
                    ({1'b0, byte_index_i, LANE_W'(b)} < piu_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_ACCUM) state_d = ST_ACC;
        else if (in_acc && cmd == CMD_READ) state_d = ST_READ;
      end
      ST_ACC:   if (last_col) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_IDLE;
      ST_READ:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    acc_re     = 1'b0;
    acc_raddr  = col_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        acc_re     = in_valid_i && cmd == CMD_READ;
        acc_raddr  = power_index_i;
      end
      ST_ACC:  acc_re = 1'b1;
      default: ;
    endcase
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    gsa_ram #(
      .WIDTH(GF_WIDTH),
      .DEPTH(MAX_POINTS / LANES * SYNDROME_LEN)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (in_acc && cmd == CMD_WRITE && point_index_i[LANE_W-1:0] == LANE_W'(g)),
      .waddr_i ({point_index_i[PT_W-1:LANE_W], power_index_i}),
      .wdata_i (table_value_i),
      .re_i    (state_q == ST_ACC),
      .raddr_i ({row_q, col_q}),
      .rdata_o (lane_data[g])
    );
  end

  gsa_ram #(
    .WIDTH(GF_WIDTH),
    .DEPTH(SYNDROME_LEN)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (wb_q),
    .waddr_i (wb_col_q),
    .wdata_i (sum),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign mctrl.mask      = mask_q;
  assign mctrl.acc_valid = vld_q[wb_col_q];

  gsa_merge u_merge (
    .ctrl_i (mctrl),
    .lane_i (lane_data),
    .acc_i  (acc_rdata),
    .sum_o  (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      piu_q       <= PIU_W'(MAX_POINTS);
      col_q       <= '0;
      wb_q        <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) piu_q <= cfg_data_i;
      wb_q <= (state_q == ST_ACC);
      if (state_q == ST_ACC) col_q <= col_q + 1'b1;
      else col_q <= '0;
      if (in_acc && cmd == CMD_CLEAR) vld_q <= '0;
      else if (wb_q) vld_q[wb_col_q] <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_col_q <= col_q;
    if (in_acc && cmd == CMD_ACCUM) begin
      row_q  <= byte_index_i;
      mask_q <= mask_new;
    end
    if (in_acc && cmd == CMD_READ) rd_idx_q <= power_index_i;
    if (out_load) begin
      syn_q <= vld_q[rd_idx_q] ? acc_rdata : '0;
      idx_q <= rd_idx_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign syndrome_word_o = syn_q;
  assign word_index_o    = idx_q;

endmodule

### test/goppa_syndrome_accumulator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goppa_syndrome_accumulator_unit_test
// Self-checking bench for the Goppa syndrome accumulator. Rows of the
// coefficient table are loaded, then accumulates, clears and reads run
// against a local syndrome model under several points_in_use settings.
// Accumulates only set bits whose row is fully loaded or out of range.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module goppa_syndrome_accumulator_unit_test;
  import gsa_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [12:0] word;
    logic [7:0]  index;
  } syn_read_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [PIU_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        command_i = CMD_CLEAR;
  logic [12:0]       point_index_i = '0;
  logic [7:0]        power_index_i = '0;
  logic [12:0]       table_value_i = '0;
  logic [9:0]        byte_index_i = '0;
  logic [7:0]        cipher_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [12:0]       syndrome_word_o;
  logic [7:0]        word_index_o;

  logic [12:0] coeff_tab [int];
  int          row_fill [int];
  logic [12:0] syn_acc [SYNDROME_LEN];
  int          piu_model;
  syn_read_t   pending_reads [$];
  int          errors = 0;
  int          cycles = 0;
  int          ready_mode = 0;

  goppa_syndrome_accumulator_unit uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls: stretches of always-ready, random, and mostly stalled
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    syn_read_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected read beat idx %0d", word_index_o));
      end else begin
        exp_r = pending_reads.pop_front();
        if (syndrome_word_o !== exp_r.word)
          report_mismatch($sformatf("syndrome_word %h expected %h (idx %0d)",
                                    syndrome_word_o, exp_r.word, exp_r.index));
        if (word_index_o !== exp_r.index)
          report_mismatch($sformatf("word_index %0d expected %0d",
                                    word_index_o, exp_r.index));
      end
    end
  end

  function automatic bit row_loaded(int pt);
    return row_fill.exists(pt) && row_fill[pt] == SYNDROME_LEN;
  endfunction

  function automatic bit bit_counts(int pos);
    return pos < piu_model && pos < MAX_POINTS;
  endfunction

  function automatic void predict_beat(cmd_e cmd, int pt, int pw, logic [12:0] val,
                                       int bi, logic [7:0] cb);
    int key;
    int pos;
    syn_read_t r;
    key = pt * SYNDROME_LEN + pw;
    case (cmd)
      CMD_WRITE: begin
        if (!coeff_tab.exists(key)) begin
          if (!row_fill.exists(pt)) row_fill[pt] = 0;
          row_fill[pt]++;
        end
        coeff_tab[key] = val;
      end
      CMD_CLEAR: foreach (syn_acc[i]) syn_acc[i] = '0;
      CMD_ACCUM: begin
        for (int b = 0; b < 8; b++) begin
          pos = bi * 8 + b;
          if (cb[b] && bit_counts(pos))
            foreach (syn_acc[c]) syn_acc[c] ^= coeff_tab[pos * SYNDROME_LEN + c];
        end
      end
      default: begin
        r.word = syn_acc[pw];
        r.index = pw[7:0];
        pending_reads.push_back(r);
      end
    endcase
  endfunction

  // one input beat; leaves valid high unless a gap follows
  task automatic send_beat(cmd_e cmd, int pt, int pw, logic [12:0] val, int bi,
                           logic [7:0] cb);
    int gap;
    command_i <= cmd;
    point_index_i <= pt[12:0];
    power_index_i <= pw[7:0];
    table_value_i <= val;
    byte_index_i <= bi[9:0];
    cipher_byte_i <= cb;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(cmd, pt, pw, val, bi, cb);
    gap = $urandom_range(0, 99);
    if (gap >= 60) begin
      in_valid_i <= 1'b0;
      if (gap >= 97) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_points_in_use(int v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[PIU_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    piu_model = v;
    if (piu_model > MAX_POINTS) piu_model = MAX_POINTS;
  endtask

  task automatic send_read(int pw);
    send_beat(CMD_READ, $urandom_range(0, 8191), pw, 13'($urandom_range(0, 8191)),
              $urandom_range(0, 1023), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_accum(int bi, logic [7:0] cb);
    logic [7:0] ok;
    for (int b = 0; b < 8; b++) ok[b] = !bit_counts(bi * 8 + b) || row_loaded(bi * 8 + b);
    send_beat(CMD_ACCUM, $urandom_range(0, 8191), $urandom_range(0, 255),
              13'($urandom_range(0, 8191)), bi, cb & ok);
  endtask

  task automatic send_clear();
    send_beat(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 255),
              13'($urandom_range(0, 8191)), $urandom_range(0, 1023),
              8'($urandom_range(0, 255)));
  endtask

  task automatic test_table_load();
    int rows [3] = '{0, 5, 8191};
    logic [12:0] v;
    foreach (rows[r]) begin
      for (int c = 0; c < SYNDROME_LEN; c++) begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = '1;
          default: v = 13'($urandom_range(0, 8191));
        endcase
        send_beat(CMD_WRITE, rows[r], c, v, $urandom_range(0, 1023),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_directed();
    send_read(0);
    send_read(255);
    send_accum(0, 8'h21);
    send_read(0);
    send_read(255);
    send_accum(1023, 8'h80);
    send_read(128);
    send_accum(0, 8'hff);
    send_read(1);
    send_beat(CMD_WRITE, 5, 255, 13'h1fff, 0, 0);
    send_beat(CMD_WRITE, 8191, 0, 13'h0000, 1023, 8'hff);
    send_accum(0, 8'h20);
    send_read(255);
    send_clear();
    send_read(255);
    send_accum(1023, 8'hff);
    send_read(0);
  endtask

  task automatic test_points_in_use();
    int settings [6] = '{1, 0, 6, 16383, 8191, 8192};
    foreach (settings[s]) begin
      write_points_in_use(settings[s]);
      send_clear();
      send_accum(0, 8'hff);
      send_read($urandom_range(0, 255));
      send_accum(1023, 8'h80);
      send_read(255);
      send_read(0);
    end
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if ($urandom_range(0, 1) == 1)
        send_beat(CMD_WRITE, ($urandom_range(0, 2) == 0) ? 5 : 8191,
                  $urandom_range(0, 255), 13'($urandom_range(0, 8191)),
                  $urandom_range(0, 1023), 8'($urandom_range(0, 255)));
      else
        send_beat(CMD_WRITE, $urandom_range(0, 8191), $urandom_range(0, 255),
                  13'($urandom_range(0, 8191)), $urandom_range(0, 1023),
                  8'($urandom_range(0, 255)));
    end else if (pick < 25) begin
      send_clear();
    end else if (pick < 50) begin
      case ($urandom_range(0, 3))
        0: send_accum(0, 8'($urandom_range(0, 255)));
        1: send_accum(1023, 8'($urandom_range(0, 255)));
        default: send_accum($urandom_range(0, 1023), 8'($urandom_range(0, 255)));
      endcase
    end else begin
      send_read($urandom_range(0, 255));
    end
  endtask

  task automatic test_random();
    int piu_pick [4] = '{8192, 3, 8190, 16383};
    foreach (piu_pick[p]) begin
      write_points_in_use(piu_pick[p]);
      for (int i = 0; i < 182; i++) begin
        random_item();
        if (i == 60) wait_drained();
      end
    end
  endtask

  initial begin
    piu_model = MAX_POINTS;
    foreach (syn_acc[i]) syn_acc[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed();
    test_points_in_use();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
